// File: hdl/bra_pkg.sv
// Package for the resource allocator: sizes, codes and request/result types.
// No dependencies.
package bra_pkg;
  localparam int NumKinds   = 4;
  localparam int NumClients = 16;
  localparam int KindW      = $clog2(NumKinds);
  localparam int SlotW      = $clog2(NumClients);
  localparam int CntW       = $clog2(NumClients + 1);
  localparam int CfgRegs    = 5;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 16;
  localparam int UnitW      = 16;
  localparam int AmtW       = 17;
  localparam int WorkW      = UnitW + CntW;

  localparam logic [CfgIdxW-1:0] CfgResCount = 3'd0;

  typedef enum logic [1:0] {
    ActInit    = 2'd0,
    ActRequest = 2'd1,
    ActClose   = 2'd2,
    ActEnd     = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    StAck       = 4'd0,
    StWait      = 4'd1,
    StUnconfig  = 4'd2,
    StDuplicate = 4'd3,
    StClaimBig  = 4'd4,
    StUnknown   = 4'd5,
    StClosed    = 4'd6,
    StOverNeed  = 4'd7,
    StOverRel   = 4'd8,
    StOpen      = 4'd9,
    StFull      = 4'd10
  } status_e;

  typedef struct packed {
    logic [1:0]                        action;
    logic [7:0]                        tag;
    logic signed [NumKinds-1:0][AmtW-1:0] amount;
  } req_t;

  typedef struct packed {
    logic [3:0] status;
  } rsp_t;

  function automatic logic [UnitW-1:0] clamp_units(input logic signed [AmtW+1:0] v);
    logic [UnitW-1:0] r;
    begin
      if (v < 0) r = '0;
      else if (v > $signed({2'b00, {AmtW{1'b0}}} | (AmtW+2)'(65535))) r = '1;
      else r = v[UnitW-1:0];
      return r;
    end
  endfunction
endpackage

// File: hdl/bra_stream_if.sv
// Valid/ready channel carrying one payload type.
// Uses bra_pkg types through the parameterless payload.
interface bra_req_if import bra_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bra_rsp_if import bra_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/banker_resource_allocator.sv
// Top level of the banker's-algorithm resource allocator.
// Depends on bra_pkg, bra_stream_if and bra_table.
//
// One request is handled at a time. Each request scans the client table one
// slot per cycle through a single table read port: a lookup pass over the
// table (N is the number of table slots), then for a grant a safety check
// of up to N passes over the table, and a rollback write when unsafe. The
// input is not ready from an accepted request until its result is
// registered. The result sits in its own register, so a stalled result does
// not stop the next request from being taken and worked on; only that
// request's result then waits until the stalled one is taken.
// Alloc of a slot is written to zero on init, so no clearing pass is needed.
module banker_resource_allocator import bra_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  bra_req_if.sink              req,
  bra_rsp_if.source            rsp
);
  typedef enum logic [3:0] {
    SIdle, SLook, SLookEnd, SDecide, SSafe, SSafeEnd, SRoll, SResp
  } state_e;

  state_e                          state_q;
  logic [2:0]                      rescnt_q;
  logic [NumKinds-1:0][UnitW-1:0]  avail_q;
  logic [NumClients-1:0]           valid_q, closed_q;
  logic [7:0]                      tag_q [NumClients];
  logic [CntW-1:0]                 reg_cnt_q, closed_cnt_q;
  req_t                            r_q;
  logic [SlotW:0]                  cnt_q;
  logic                            hit_q;
  logic [SlotW-1:0]                slot_q;
  logic [NumKinds-1:0][UnitW-1:0]  s_alloc_q, s_need_q;
  logic [NumKinds-1:0][WorkW-1:0]  work_q;
  logic [NumClients-1:0]           done_q;
  logic                            prog_q;
  logic [3:0]                      status_q;
  logic [3:0]                      rsp_status_q;
  logic                            rvalid_q;

  logic [NumKinds-1:0][UnitW-1:0]  rd_alloc, rd_need;
  logic                            wr_en;
  logic [SlotW-1:0]                wr_slot;
  logic [NumKinds-1:0][UnitW-1:0]  wr_alloc, wr_need;
  logic [SlotW-1:0]                rd_slot;
  logic [NumKinds-1:0]             kmask;
  logic [SlotW-1:0]                prev;
  logic                            prev_ok;

  always_comb begin
    for (int k = 0; k < NumKinds; k++) kmask[k] = (3'(k) < rescnt_q);
  end

  assign rd_slot = cnt_q[SlotW-1:0];
  assign prev    = SlotW'(cnt_q - 1'b1);
  assign prev_ok = (cnt_q != '0);

  bra_table u_table (
    .clk_i, .rd_slot_i(rd_slot), .rd_alloc_o(rd_alloc), .rd_need_o(rd_need),
    .wr_en_i(wr_en), .wr_slot_i(wr_slot), .wr_alloc_i(wr_alloc), .wr_need_i(wr_need)
  );

  // apply/rollback of the looked-up slot
  logic [NumKinds-1:0][UnitW-1:0] ap_alloc, ap_need, rb_alloc, rb_need;
  logic [NumKinds-1:0][UnitW-1:0] ap_avail, rb_avail;
  always_comb begin
    for (int k = 0; k < NumKinds; k++) begin
      logic signed [AmtW+1:0] a;
      a = (AmtW+2)'($signed(r_q.amount[k]));
      if (kmask[k]) begin
        ap_avail[k] = clamp_units($signed({2'b0, avail_q[k]}) - a);
        ap_alloc[k] = clamp_units($signed({2'b0, s_alloc_q[k]}) + a);
        ap_need[k]  = clamp_units($signed({2'b0, s_need_q[k]}) - a);
        rb_avail[k] = clamp_units($signed({2'b0, avail_q[k]}) + a);
        rb_alloc[k] = clamp_units($signed({2'b0, s_alloc_q[k]}) - a);
        rb_need[k]  = clamp_units($signed({2'b0, s_need_q[k]}) + a);
      end else begin
        ap_avail[k] = avail_q[k]; rb_avail[k] = avail_q[k];
        ap_alloc[k] = s_alloc_q[k]; rb_alloc[k] = s_alloc_q[k];
        ap_need[k]  = s_need_q[k]; rb_need[k]  = s_need_q[k];
      end
    end
  end

  // decision logic
  logic free_any;
  logic [SlotW-1:0] free_slot;
  always_comb begin
    free_any = 1'b0; free_slot = '0;
    for (int i = NumClients-1; i >= 0; i--)
      if (!valid_q[i]) begin free_any = 1'b1; free_slot = SlotW'(i); end
  end

  logic cfg_any, claim_bad, over_need, over_rel, over_av, holds;
  always_comb begin
    cfg_any = 1'b0; claim_bad = 1'b0; over_need = 1'b0;
    over_rel = 1'b0; over_av = 1'b0; holds = 1'b0;
    for (int k = 0; k < NumKinds; k++) begin
      logic signed [AmtW+1:0] a;
      a = (AmtW+2)'($signed(r_q.amount[k]));
      if (kmask[k]) begin
        if (avail_q[k] != '0) cfg_any = 1'b1;
        if (a < 0 || a > $signed({2'b0, avail_q[k]})) claim_bad = 1'b1;
        if (a > $signed({2'b0, s_need_q[k]})) over_need = 1'b1;
        if (a + $signed({2'b0, s_alloc_q[k]}) < 0) over_rel = 1'b1;
        if (a > $signed({2'b0, avail_q[k]})) over_av = 1'b1;
        if (s_alloc_q[k] != '0) holds = 1'b1;
      end
    end
  end

  // safety check: entry read last cycle
  logic fits;
  always_comb begin
    fits = 1'b1;
    for (int k = 0; k < NumKinds; k++)
      if (kmask[k] && WorkW'(rd_need[k]) > work_q[k]) fits = 1'b0;
  end

  always_comb begin
    wr_en = 1'b0; wr_slot = slot_q; wr_alloc = ap_alloc; wr_need = ap_need;
    if (state_q == SDecide) begin
      if (r_q.action == ActInit) begin
        wr_slot = free_slot;
        for (int k = 0; k < NumKinds; k++) begin
          wr_alloc[k] = '0;
          wr_need[k]  = kmask[k] ? r_q.amount[k][UnitW-1:0] : '0;
        end
        wr_en = cfg_any && !hit_q && !claim_bad && free_any;
      end else if (r_q.action == ActRequest) begin
        wr_en = hit_q && !closed_q[slot_q] && !over_need && !over_rel && !over_av;
      end
    end else if (state_q == SRoll) begin
      wr_en = 1'b1; wr_alloc = rb_alloc; wr_need = rb_need;
    end
  end

  assign req.ready = (state_q == SIdle);
  assign rsp.valid = rvalid_q;
  assign rsp.data.status = rsp_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; rescnt_q <= 3'd4; avail_q <= '0;
      valid_q <= '0; closed_q <= '0; reg_cnt_q <= '0; closed_cnt_q <= '0;
      rvalid_q <= 1'b0; status_q <= '0; cnt_q <= '0; hit_q <= 1'b0;
      slot_q <= '0; prog_q <= 1'b0; done_q <= '0; rsp_status_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgResCount) rescnt_q <= cfg_data_i[2:0];
        else if (cfg_idx_i < CfgIdxW'(CfgRegs) && int'(cfg_idx_i) - 1 < NumKinds)
          avail_q[KindW'(cfg_idx_i - 1'b1)] <= cfg_data_i;
      end
      if (rvalid_q && rsp.ready && state_q != SResp) rvalid_q <= 1'b0;
      unique case (state_q)
        SIdle: if (req.valid) begin
          r_q <= req.data; cnt_q <= '0; hit_q <= 1'b0;
          state_q <= SLook;
        end
        SLook, SLookEnd: begin
          if (prev_ok && valid_q[prev] && tag_q[prev] == r_q.tag) begin
            hit_q <= 1'b1; slot_q <= prev; s_alloc_q <= rd_alloc; s_need_q <= rd_need;
          end
          if (state_q == SLookEnd) state_q <= SDecide;
          else begin
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == (SlotW+1)'(NumClients-1)) state_q <= SLookEnd;
          end
        end
        SDecide: begin
          state_q <= SResp;
          unique case (r_q.action)
            ActInit: begin
              if (!cfg_any) status_q <= StUnconfig;
              else if (hit_q) status_q <= StDuplicate;
              else if (claim_bad) status_q <= StClaimBig;
              else if (!free_any) status_q <= StFull;
              else begin
                status_q <= StAck;
                valid_q[free_slot] <= 1'b1; closed_q[free_slot] <= 1'b0;
                tag_q[free_slot] <= r_q.tag; reg_cnt_q <= reg_cnt_q + 1'b1;
              end
            end
            ActRequest: begin
              if (!hit_q) status_q <= StUnknown;
              else if (closed_q[slot_q]) status_q <= StClosed;
              else if (over_need) status_q <= StOverNeed;
              else if (over_rel) status_q <= StOverRel;
              else if (over_av) status_q <= StWait;
              else begin
                avail_q <= ap_avail; s_alloc_q <= ap_alloc; s_need_q <= ap_need;
                for (int k = 0; k < NumKinds; k++)
                  work_q[k] <= WorkW'(ap_avail[k]);
                done_q <= ~valid_q | closed_q;
                cnt_q <= '0; prog_q <= 1'b0; state_q <= SSafe;
              end
            end
            ActClose: begin
              if (!hit_q) status_q <= StUnknown;
              else if (holds) status_q <= StOpen;
              else begin
                status_q <= StAck;
                if (!closed_q[slot_q]) begin
                  closed_q[slot_q] <= 1'b1; closed_cnt_q <= closed_cnt_q + 1'b1;
                end
              end
            end
            ActEnd: status_q <= (closed_cnt_q < reg_cnt_q) ? StOpen : StAck;
            default: status_q <= StAck;
          endcase
        end
        SSafe, SSafeEnd: begin
          logic take;
          take = prev_ok && !done_q[prev] && fits;
          if (take) begin
            done_q[prev] <= 1'b1; prog_q <= 1'b1;
            for (int k = 0; k < NumKinds; k++)
              if (kmask[k]) work_q[k] <= work_q[k] + WorkW'(rd_alloc[k]);
          end
          if (state_q == SSafeEnd) begin
            if (&(done_q | (take ? (NumClients'(1) << prev) : '0))) begin
              status_q <= StAck; state_q <= SResp;
            end else if (!prog_q && !take) begin
              state_q <= SRoll;
            end else begin
              cnt_q <= '0; prog_q <= 1'b0; state_q <= SSafe;
            end
          end else begin
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == (SlotW+1)'(NumClients-1)) state_q <= SSafeEnd;
          end
        end
        SRoll: begin
          avail_q <= rb_avail; status_q <= StWait; state_q <= SResp;
        end
        SResp: if (!rvalid_q || rsp.ready) begin
          rvalid_q <= 1'b1; rsp_status_q <= status_q; state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

// File: hdl/bra_table.sv
// Client table memory: per-slot alloc and need rows, one row read per cycle.
// Depends on bra_pkg.
module bra_table import bra_pkg::*; (
  input  logic                               clk_i,
  input  logic [SlotW-1:0]                   rd_slot_i,
  output logic [NumKinds-1:0][UnitW-1:0]     rd_alloc_o,
  output logic [NumKinds-1:0][UnitW-1:0]     rd_need_o,
  input  logic                               wr_en_i,
  input  logic [SlotW-1:0]                   wr_slot_i,
  input  logic [NumKinds-1:0][UnitW-1:0]     wr_alloc_i,
  input  logic [NumKinds-1:0][UnitW-1:0]     wr_need_i
);
  logic [NumKinds-1:0][UnitW-1:0] alloc_mem [NumClients];
  logic [NumKinds-1:0][UnitW-1:0] need_mem  [NumClients];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      alloc_mem[wr_slot_i] <= wr_alloc_i;
      need_mem[wr_slot_i]  <= wr_need_i;
    end
    rd_alloc_o <= alloc_mem[rd_slot_i];
    rd_need_o  <= need_mem[rd_slot_i];
  end
endmodule

// File: hdl/bra_checker.sv
// Port-level checks for the allocator, bound to the top level.
// Depends on bra_pkg and the top level's ports.
module bra_checker import bra_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [3:0] rsp_status_i
);
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_status_i <= 4'(StFull)) else $error("status out of range");
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i) else $error("ready during work");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i))
    else $error("rsp dropped");
  a_no_rsp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $rose(req_ready_i)) else $error("rsp without finish");
endmodule

bind banker_resource_allocator bra_checker u_bra_checker (
  .clk_i, .rst_ni, .req_valid_i(req.valid), .req_ready_i(req.ready),
  .rsp_valid_i(rsp.valid), .rsp_ready_i(rsp.ready), .rsp_status_i(rsp.data.status)
);

// File: verif/banker_resource_allocator_tb.sv
// Self-checking testbench for banker_resource_allocator: random and directed
// client requests, a predictor of the allocator table and status checks.
// Depends on bra_pkg, bra_stream_if and the allocator RTL.
module banker_resource_allocator_tb;
  import bra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int UnitMax = 65535;
  localparam int IdleLimit = 20000;
  localparam logic [CfgIdxW-1:0] CfgTotal0 = 3'd1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  bra_req_if req_ch ();
  bra_rsp_if rsp_ch ();

  banker_resource_allocator dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .req(req_ch.sink), .rsp(rsp_ch.source)
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  int unsigned res_count;
  int unsigned avail[NumKinds];
  bit slot_valid[NumClients];
  bit slot_closed[NumClients];
  int unsigned slot_tag[NumClients];
  int unsigned slot_alloc[NumClients][NumKinds];
  int unsigned slot_need[NumClients][NumKinds];
  int unsigned reg_cnt, closed_cnt;

  req_t pending_reqs[$];
  status_e status_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int tx_gap = 0, rx_gap = 0;

  function automatic int unsigned clamp_u(longint v);
    if (v < 0) return 0;
    if (v > UnitMax) return UnitMax;
    return int'(v);
  endfunction

  function automatic int find_tag(int unsigned tag);
    for (int i = 0; i < NumClients; i++)
      if (slot_valid[i] && slot_tag[i] == tag) return i;
    return -1;
  endfunction

  function automatic bit table_safe(int nk);
    longint work[NumKinds];
    bit fin[NumClients];
    int left;
    bit progress, fits;
    left = 0;
    for (int k = 0; k < NumKinds; k++) work[k] = avail[k];
    for (int i = 0; i < NumClients; i++) begin
      fin[i] = !slot_valid[i] || slot_closed[i];
      if (!fin[i]) left++;
    end
    while (left > 0) begin
      progress = 0;
      for (int i = 0; i < NumClients; i++) begin
        if (fin[i]) continue;
        fits = 1;
        for (int k = 0; k < nk; k++) if (longint'(slot_need[i][k]) > work[k]) fits = 0;
        if (fits) begin
          for (int k = 0; k < nk; k++) work[k] += slot_alloc[i][k];
          fin[i] = 1;
          left--;
          progress = 1;
        end
      end
      if (!progress) return 0;
    end
    return 1;
  endfunction

  function automatic void apply_grant(int s, longint amt[NumKinds], int nk, longint sgn);
    longint d;
    for (int k = 0; k < nk; k++) begin
      d = sgn * amt[k];
      avail[k] = clamp_u(longint'(avail[k]) - d);
      slot_alloc[s][k] = clamp_u(longint'(slot_alloc[s][k]) + d);
      slot_need[s][k] = clamp_u(longint'(slot_need[s][k]) - d);
    end
  endfunction

  function automatic status_e predict_status(req_t r);
    longint amt[NumKinds];
    int nk, s;
    bit any;
    nk = res_count > NumKinds ? NumKinds : res_count;
    for (int k = 0; k < NumKinds; k++) amt[k] = longint'($signed(r.amount[k]));
    case (action_e'(r.action))
      ActInit: begin
        any = 0;
        for (int k = 0; k < nk; k++) if (avail[k] != 0) any = 1;
        if (!any) return StUnconfig;
        if (find_tag(r.tag) >= 0) return StDuplicate;
        for (int k = 0; k < nk; k++)
          if (amt[k] < 0 || amt[k] > longint'(avail[k])) return StClaimBig;
        s = -1;
        for (int i = 0; i < NumClients; i++) if (s < 0 && !slot_valid[i]) s = i;
        if (s < 0) return StFull;
        slot_valid[s] = 1;
        slot_tag[s] = r.tag;
        slot_closed[s] = 0;
        for (int k = 0; k < NumKinds; k++) begin
          slot_alloc[s][k] = 0;
          slot_need[s][k] = k < nk ? clamp_u(amt[k]) : 0;
        end
        reg_cnt++;
        return StAck;
      end
      ActRequest: begin
        s = find_tag(r.tag);
        if (s < 0) return StUnknown;
        if (slot_closed[s]) return StClosed;
        for (int k = 0; k < nk; k++)
          if (amt[k] > longint'(slot_need[s][k])) return StOverNeed;
        for (int k = 0; k < nk; k++)
          if (amt[k] + longint'(slot_alloc[s][k]) < 0) return StOverRel;
        for (int k = 0; k < nk; k++) if (amt[k] > longint'(avail[k])) return StWait;
        apply_grant(s, amt, nk, 1);
        if (!table_safe(nk)) begin
          apply_grant(s, amt, nk, -1);
          return StWait;
        end
        return StAck;
      end
      ActClose: begin
        s = find_tag(r.tag);
        if (s < 0) return StUnknown;
        for (int k = 0; k < nk; k++) if (slot_alloc[s][k] != 0) return StOpen;
        if (!slot_closed[s]) begin
          slot_closed[s] = 1;
          closed_cnt++;
        end
        return StAck;
      end
      default: return closed_cnt < reg_cnt ? StOpen : StAck;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    errors++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        status_q.push_back(predict_status(req_ch.data));
        void'(pending_reqs.pop_front());
        tx_gap = $urandom_range(0, 9);
      end
      if ((!req_ch.valid || req_ch.ready) && pending_reqs.size() > 0 && tx_gap == 0 &&
          !(req_ch.valid && req_ch.ready && pending_reqs.size() == 0)) begin
        req_ch.valid <= 1'b1;
        req_ch.data <= pending_reqs[0];
      end else if (req_ch.ready || !req_ch.valid) begin
        req_ch.valid <= 1'b0;
        if (tx_gap > 0) tx_gap--;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (status_q.size() == 0)
          report_mismatch($sformatf("unexpected status %0d", rsp_ch.data.status));
        else if (rsp_ch.data.status != status_q[0])
          report_mismatch($sformatf("status %0d, expected %0d",
                                    rsp_ch.data.status, status_q[0]));
        if (status_q.size() > 0) void'(status_q.pop_front());
        rx_gap = $urandom_range(0, 9);
      end
      if (rx_gap > 0) begin
        rx_gap--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgResCount) res_count = val & 7;
    else avail[idx - 1] = val & 16'hffff;
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && !req_ch.valid && status_q.size() == 0);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic req_t make_req(action_e act, int unsigned tag, int a0, int a1,
                                    int a2, int a3);
    req_t r;
    r.action = act;
    r.tag = tag[7:0];
    r.amount[0] = a0[AmtW-1:0];
    r.amount[1] = a1[AmtW-1:0];
    r.amount[2] = a2[AmtW-1:0];
    r.amount[3] = a3[AmtW-1:0];
    return r;
  endfunction

  function automatic int rand_amt(int unsigned lim);
    int v;
    case ($urandom_range(0, 9))
      0: v = -int'($urandom_range(0, 65535));
      1: v = int'($urandom_range(0, 65535));
      2: v = ($urandom_range(0, 1) ? 65535 : -65535);
      3, 4: v = -int'($urandom_range(0, lim));
      default: v = int'($urandom_range(0, lim));
    endcase
    return v;
  endfunction

  task automatic random_phase(int n, int unsigned lim);
    int unsigned tags[8];
    int unsigned t;
    req_t r;
    for (int i = 0; i < 8; i++) tags[i] = $urandom_range(0, 255);
    for (int i = 0; i < n; i++) begin
      t = $urandom_range(0, 15) == 0 ? $urandom_range(0, 255) : tags[$urandom_range(0, 7)];
      case ($urandom_range(0, 19))
        0, 1, 2, 3: r = make_req(ActInit, t, $urandom_range(0, lim), $urandom_range(0, lim),
                                 $urandom_range(0, lim), $urandom_range(0, lim));
        4: r = make_req(ActInit, t, rand_amt(65535), rand_amt(65535),
                        rand_amt(65535), rand_amt(65535));
        5, 6: r = make_req(ActClose, t, rand_amt(lim), rand_amt(lim),
                           rand_amt(lim), rand_amt(lim));
        7: r = make_req(ActEnd, t, rand_amt(lim), rand_amt(lim), rand_amt(lim), rand_amt(lim));
        default: r = make_req(ActRequest, t, rand_amt(lim), rand_amt(lim),
                              rand_amt(lim), rand_amt(lim));
      endcase
      pending_reqs.push_back(r);
    end
    drain();
  endtask

  initial begin
    res_count = 4;
    reg_cnt = 0;
    closed_cnt = 0;
    for (int k = 0; k < NumKinds; k++) avail[k] = 0;
    for (int i = 0; i < NumClients; i++) begin
      slot_valid[i] = 0;
      slot_closed[i] = 0;
      slot_tag[i] = 0;
      for (int k = 0; k < NumKinds; k++) begin
        slot_alloc[i][k] = 0;
        slot_need[i][k] = 0;
      end
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // unconfigured init, then directed cases
    pending_reqs.push_back(make_req(ActInit, 1, 1, 1, 1, 1));
    pending_reqs.push_back(make_req(ActEnd, 0, 0, 0, 0, 0));
    drain();
    write_reg(CfgResCount, 4);
    for (int k = 0; k < 4; k++) write_reg(CfgIdxW'(CfgTotal0 + k), 10);
    pending_reqs.push_back(make_req(ActInit, 1, -1, 0, 0, 0));
    pending_reqs.push_back(make_req(ActInit, 1, 11, 0, 0, 0));
    pending_reqs.push_back(make_req(ActInit, 1, 8, 8, 8, 8));
    pending_reqs.push_back(make_req(ActInit, 1, 1, 1, 1, 1));
    pending_reqs.push_back(make_req(ActInit, 2, 8, 8, 8, 8));
    pending_reqs.push_back(make_req(ActRequest, 9, 1, 0, 0, 0));
    pending_reqs.push_back(make_req(ActRequest, 1, 9, 0, 0, 0));
    pending_reqs.push_back(make_req(ActRequest, 1, -1, 0, 0, 0));
    pending_reqs.push_back(make_req(ActRequest, 1, 5, 5, 5, 5));
    pending_reqs.push_back(make_req(ActRequest, 2, 5, 5, 5, 5));
    pending_reqs.push_back(make_req(ActRequest, 1, 3, 3, 3, 3));
    pending_reqs.push_back(make_req(ActClose, 1, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(ActRequest, 1, -8, -8, -8, -8));
    pending_reqs.push_back(make_req(ActClose, 1, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(ActClose, 1, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(ActRequest, 1, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(ActInit, 1, 1, 1, 1, 1));
    pending_reqs.push_back(make_req(ActClose, 77, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(ActEnd, 0, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(ActClose, 2, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(ActEnd, 0, 0, 0, 0, 0));
    for (int i = 0; i < 16; i++) pending_reqs.push_back(make_req(ActInit, 100 + i, 0, 0, 0, 0));
    drain();
    // overflow on release after totals shrink and grow
    write_reg(CfgTotal0, 65535);
    random_phase(300, 8);
    write_reg(CfgResCount, 1);
    write_reg(CfgTotal0, 65535);
    write_reg(CfgIdxW'(CfgTotal0 + 1), 0);
    random_phase(300, 65535);
    write_reg(CfgResCount, 0);
    random_phase(30, 20);
    write_reg(CfgResCount, 7);
    for (int k = 0; k < 4; k++) write_reg(CfgIdxW'(CfgTotal0 + k), $urandom_range(1, 30));
    random_phase(400, 12);
    write_reg(CfgResCount, 2);
    write_reg(CfgTotal0, 0);
    write_reg(CfgIdxW'(CfgTotal0 + 1), 20);
    write_reg(CfgIdxW'(CfgTotal0 + 2), 65535);
    write_reg(CfgIdxW'(CfgTotal0 + 3), 65535);
    random_phase(350, 20);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// File: files.f
hdl/bra_pkg.sv
hdl/bra_stream_if.sv
hdl/bra_table.sv
hdl/banker_resource_allocator.sv
hdl/bra_checker.sv
verif/banker_resource_allocator_tb.sv
